// ===== sv/ult_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ult_pkg: shared types and constants of the unordered list table
// Holds the table depth, operation and status codes, request and response
// structs, the cell control struct and the controller states.
// ----------------------------------------------------------------------------
package ult_pkg;

  // table geometry
  localparam int unsigned Depth       = 16;
  localparam int unsigned CntW        = $clog2(Depth + 1);
  localparam int unsigned DataW       = 32;
  localparam int unsigned EntryCountW = 5;

  // operation codes, code 3 is a no-op
  typedef enum logic [1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_SEARCH = 2'd1,
    FUNC_DELETE = 2'd2
  } ult_func_e;

  // response status codes
  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_MISSING = 2'd2
  } ult_status_e;

  // controller states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } ult_state_e;

  // one request
  typedef struct packed {
    ult_func_e               func;
    logic signed [DataW-1:0] value;
  } ult_req_t;

  // one response
  typedef struct packed {
    logic                   found;
    ult_status_e            status;
    logic [EntryCountW-1:0] entry_count;
  } ult_rsp_t;

  // control broadcast to every cell
  typedef struct packed {
    logic cmp;   // latch compare against incoming value
    logic app;   // commit an append
    logic del;   // commit a delete with a match
  } ult_cell_ctl_t;

endpackage

// ===== sv/ult_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ult_cell: one entry of the list table
// Holds one stored word, latches its own compare result, passes a running
// match flag to the next cell and takes its upper neighbor's word on delete.
// ----------------------------------------------------------------------------
module ult_cell import ult_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ult_cell_ctl_t           ctl_i,
  input  logic signed [DataW-1:0] value_i,
  input  logic                    valid_i,     // entry lies below the count
  input  logic                    wr_sel_i,    // entry is the append slot
  input  logic signed [DataW-1:0] nbr_data_i,  // word of the next cell up
  input  logic                    hit_prev_i,  // a lower cell matched
  output logic signed [DataW-1:0] data_o,
  output logic                    hit_chain_o  // this or a lower cell matched
);

  logic signed [DataW-1:0] data_q;
  logic                    hit_q;

  // compare result, latched when a request is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (ctl_i.cmp) begin
      hit_q <= valid_i && (data_q == value_i);
    end
  end

  // running first-match flag
  assign hit_chain_o = hit_prev_i | hit_q;

  // stored word: append write or shift down past the deleted entry
  always_ff @(posedge clk_i) begin
    if (ctl_i.app && wr_sel_i) begin
      data_q <= value_i;
    end else if (ctl_i.del && hit_chain_o) begin
      data_q <= nbr_data_i;
    end
  end

  assign data_o = data_q;

endmodule

// ===== sv/unordered_list_table_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unordered_list_table_top: unsorted list of signed words with a count
// Append, search and delete-first-match over a row of entry cells.
// ----------------------------------------------------------------------------
// A request is taken in ST_IDLE, and at the edge that takes it every cell
// compares its word with the request value and latches the result. In
// ST_EXEC the running match flag ripples through the row of cells, the
// first matching cell and those past it take their upper neighbor's word,
// an append writes the slot at the count, and the response is loaded into
// the output register. A new request is taken once the previous one has
// committed, even while its response still waits; the commit of a request
// waits while the output register holds a response that is stalled.
// ----------------------------------------------------------------------------
module unordered_list_table_top import ult_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  ult_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output ult_rsp_t out_rsp_o
);

  ult_state_e              state_q, state_d;
  ult_req_t                req_q;
  logic [CntW-1:0]         count_q, count_d;
  logic                    out_valid_q, out_valid_d;
  ult_rsp_t                rsp_q, rsp_d;
  logic                    accept;
  logic                    commit;
  logic                    any_hit;
  ult_cell_ctl_t           ctl;
  logic signed [DataW-1:0] cell_value;

  logic signed [DataW-1:0] cell_data [Depth];
  logic                    hit_chain [Depth];

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign any_hit    = hit_chain[Depth-1];

  // value broadcast: incoming value on compare, held value on commit
  assign cell_value = accept ? in_req_i.value : req_q.value;

  // request holding register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_req_i;
    end
  end

  // state, count and output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      rsp_q <= rsp_d;
    end
  end

  // next state, cell control and response
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    commit      = 1'b0;
    ctl         = '0;
    ctl.cmp     = accept;
    rsp_d       = '0;
    rsp_d.status = STAT_OK;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!out_valid_q || !out_stall_i) begin
          commit      = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          case (req_q.func)
            FUNC_APPEND: begin
              if (count_q >= CntW'(Depth)) begin
                rsp_d.status = STAT_FULL;
              end else begin
                ctl.app = 1'b1;
                count_d = count_q + CntW'(1);
              end
            end
            FUNC_SEARCH: begin
              rsp_d.found = any_hit;
              if (!any_hit) begin
                rsp_d.status = STAT_MISSING;
              end
            end
            FUNC_DELETE: begin
              rsp_d.found = any_hit;
              if (any_hit) begin
                ctl.del = 1'b1;
                count_d = count_q - CntW'(1);
              end else begin
                rsp_d.status = STAT_MISSING;
              end
            end
            default: begin
            end
          endcase
          rsp_d.entry_count = EntryCountW'(count_d);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // row of entry cells
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic signed [DataW-1:0] nbr_data;
    logic                    hit_prev;

    if (i == Depth - 1) begin : g_last
      assign nbr_data = cell_data[i];
    end else begin : g_mid
      assign nbr_data = cell_data[i+1];
    end

    if (i == 0) begin : g_first
      assign hit_prev = 1'b0;
    end else begin : g_rest
      assign hit_prev = hit_chain[i-1];
    end

    ult_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .value_i     (cell_value),
      .valid_i     (count_q > CntW'(i)),
      .wr_sel_i    (count_q == CntW'(i)),
      .nbr_data_i  (nbr_data),
      .hit_prev_i  (hit_prev),
      .data_o      (cell_data[i]),
      .hit_chain_o (hit_chain[i])
    );
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

// ===== sv/ult_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ult_port_checker: port-level checks of the unordered list table
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module ult_port_checker import ult_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input ult_req_t in_req_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input ult_rsp_t out_rsp_o
);

  // stalled response holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled response changed");

  // one request in flight: a taken request blocks the next cycle
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while another is in flight");

  // a found entry always reports ok
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.found |-> out_rsp_o.status == STAT_OK)
    else $error("found with non-ok status");

  // count never exceeds the table depth
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_rsp_o.entry_count <= EntryCountW'(Depth))
    else $error("entry count beyond depth");

  // a full refusal reports the table full
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status == STAT_FULL |->
      out_rsp_o.entry_count == EntryCountW'(Depth))
    else $error("full status with table not full");

endmodule

bind unordered_list_table_top ult_port_checker u_ult_checker (.*);
